### rtl/bcci_pkg.sv
// Shared types, curve tables and constants for the battery charge interpolator.
`timescale 1ns / 1ps

package bcci_pkg;

    localparam int VoltW   = 13;
    localparam int ChargeW = 8;
    localparam int SegW    = 3;
    localparam int DeltaW  = 8;
    localparam int PctW    = 7;
    localparam int DpW     = 5;
    localparam int ShiftW  = 3;
    localparam int NumW    = 17;
    localparam int QuotW   = 12;
    localparam int ProdW   = 35;

    // floor(n / 25) == (n * DIV_MULT) >> DIV_SHIFT for every n below 2^17
    localparam int DIV_SHIFT = 22;
    localparam logic [17:0] DIV_MULT = 18'd167773;

    localparam logic [ChargeW-1:0] FULL_CHARGE = 8'd200;

    localparam logic [VoltW-1:0] LI_TOP     = 13'd3000;
    localparam logic [VoltW-1:0] LI_BOTTOM  = 13'd2500;
    localparam logic [VoltW-1:0] NI_TOP     = 13'd2900;
    localparam logic [VoltW-1:0] NI_BOTTOM  = 13'd2000;

    // One curve segment: upper end v1, span d, percent p1 at v1, percent drop dp.
    // base = 4*p1*d + d; result = (base - 4*delta*dp) / (2*d), 2*d = 25 << shift.
    typedef struct packed {
        logic [VoltW-1:0]  v1;
        logic [DpW-1:0]    dp;
        logic [ShiftW-1:0] shift;
        logic [NumW-1:0]   base;
    } seg_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic              lith;
        logic [SegW-1:0]   seg;
        logic [DeltaW-1:0] delta;
    } loc_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [ShiftW-1:0] shift;
        logic [NumW-1:0]   num;
    } num_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [ShiftW-1:0] shift;
        logic [QuotW-1:0]  quot;
    } quot_t;

    function automatic seg_t make_seg(input int v1, input int d, input int p1,
                                      input int dp, input int shift);
        seg_t s;
        s.v1    = VoltW'(v1);
        s.dp    = DpW'(dp);
        s.shift = ShiftW'(shift);
        s.base  = NumW'(4 * p1 * d + d);
        return s;
    endfunction

    // Unused lithium slot has v1 = 0 so it never wins the segment count.
    function automatic seg_t seg_lookup(input logic lith, input logic [SegW-1:0] idx);
        seg_t s;
        s = make_seg(0, 0, 0, 0, 0);
        if (lith)
        begin
            unique case (idx)
                3'd0:    s = make_seg(3000,  50, 100, 10, 2);
                3'd1:    s = make_seg(2950,  50,  90, 10, 2);
                3'd2:    s = make_seg(2900,  50,  80, 20, 2);
                3'd3:    s = make_seg(2850,  50,  60, 20, 2);
                3'd4:    s = make_seg(2800,  50,  40, 20, 2);
                3'd5:    s = make_seg(2750,  50,  20, 10, 2);
                3'd6:    s = make_seg(2700, 200,  10, 10, 4);
                default: s = make_seg(0, 0, 0, 0, 0);
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    s = make_seg(2900, 200, 100, 10, 4);
                3'd1:    s = make_seg(2700, 100,  90, 10, 3);
                3'd2:    s = make_seg(2600, 100,  80, 15, 3);
                3'd3:    s = make_seg(2500, 100,  65, 15, 3);
                3'd4:    s = make_seg(2400, 100,  50, 20, 3);
                3'd5:    s = make_seg(2300, 100,  30, 18, 3);
                3'd6:    s = make_seg(2200, 100,  12,  9, 3);
                default: s = make_seg(2100, 100,   3,  3, 3);
            endcase
        end
        return s;
    endfunction

endpackage

### rtl/bcci_locate.sv
// Stage 1: range check, segment search and distance below the segment top.
`timescale 1ns / 1ps

module bcci_locate
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bcci_pkg::VoltW-1:0] voltage,
    input  logic                       lith,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bcci_pkg::loc_t             out_beat
);

    logic           valid_reg;
    bcci_pkg::loc_t beat_reg;
    bcci_pkg::loc_t beat_next;

    always_comb
    begin
        logic [bcci_pkg::SegW-1:0] cnt;
        bcci_pkg::seg_t            hit;
        cnt = '0;
        // segment index = number of inner breakpoints still above the voltage
        for (int j = 1; j < 8; j++)
        begin
            cnt = cnt + bcci_pkg::SegW'(voltage <
                  bcci_pkg::seg_lookup(lith, bcci_pkg::SegW'(j)).v1);
        end
        hit = bcci_pkg::seg_lookup(lith, cnt);
        beat_next.lith  = lith;
        beat_next.seg   = cnt;
        beat_next.delta = bcci_pkg::DeltaW'(hit.v1 - voltage);
        beat_next.full  = lith ? (voltage >= bcci_pkg::LI_TOP)
                               : (voltage >= bcci_pkg::NI_TOP);
        beat_next.empty = lith ? (voltage <= bcci_pkg::LI_BOTTOM)
                               : (voltage <= bcci_pkg::NI_BOTTOM);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

### rtl/bcci_scale.sv
// Stages 2 and 3: interpolation numerator, then division by 25 via reciprocal.
`timescale 1ns / 1ps

module bcci_scale
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bcci_pkg::loc_t  in_beat,
    output logic            out_valid,
    input  logic            out_ready,
    output bcci_pkg::quot_t out_beat
);

    logic            num_valid_reg;
    bcci_pkg::num_t  num_reg;
    bcci_pkg::num_t  num_next;
    logic            num_ready;
    logic            quot_valid_reg;
    bcci_pkg::quot_t quot_reg;
    bcci_pkg::quot_t quot_next;

    always_comb
    begin
        bcci_pkg::seg_t                s;
        logic [bcci_pkg::NumW-5:0]     prod;
        s    = bcci_pkg::seg_lookup(in_beat.lith, in_beat.seg);
        prod = bcci_pkg::DeltaW'(in_beat.delta) * (bcci_pkg::NumW-4)'(s.dp);
        num_next.full  = in_beat.full;
        num_next.empty = in_beat.empty;
        num_next.shift = s.shift;
        num_next.num   = s.base - {prod, 2'b00};
    end

    always_comb
    begin
        logic [bcci_pkg::ProdW-1:0] mult;
        mult = bcci_pkg::ProdW'(num_reg.num) * bcci_pkg::ProdW'(bcci_pkg::DIV_MULT);
        quot_next.full  = num_reg.full;
        quot_next.empty = num_reg.empty;
        quot_next.shift = num_reg.shift;
        quot_next.quot  = mult[bcci_pkg::DIV_SHIFT +: bcci_pkg::QuotW];
    end

    assign num_ready = !quot_valid_reg || out_ready;
    assign in_ready  = !num_valid_reg || num_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg  <= 1'b0;
            quot_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                num_valid_reg <= in_valid;
            end
            if (num_ready)
            begin
                quot_valid_reg <= num_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg <= num_next;
        end
        if (num_valid_reg && num_ready)
        begin
            quot_reg <= quot_next;
        end
    end

    assign out_valid = quot_valid_reg;
    assign out_beat  = quot_reg;

endmodule

### rtl/battery_charge_curve_interpolator_top.sv
// Battery charge curve interpolator: top level with config register and output stage.
`timescale 1ns / 1ps

// Maps a battery voltage (mV) to remaining charge in half-percent units (0..200)
// by linear interpolation over a fixed lithium curve (cfg_data = 1, reset value)
// or a NiMH curve on doubled cell voltage (cfg_data = 0), rounded half up.
// Takes one beat per clock when m_axis is not stalled; each result passes through
// four pipeline registers (segment search, numerator, reciprocal multiply, final
// shift and clamp). Backpressure on m_axis stalls the pipeline stage by stage,
// bubbles are squeezed out. Write cfg only while idle.

module battery_charge_curve_interpolator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,          // battery_is_lithium
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,      // [12:0] voltage_mv, [15:13] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata       // [7:0] charge_half_percent
);

    logic                            lith_reg;
    logic                            loc_valid;
    logic                            loc_ready;
    bcci_pkg::loc_t                  loc_beat;
    logic                            quot_valid;
    logic                            quot_ready;
    bcci_pkg::quot_t                 quot_beat;
    logic                            out_valid_reg;
    logic [bcci_pkg::ChargeW-1:0]    charge_reg;
    logic [bcci_pkg::ChargeW-1:0]    charge_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lith_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lith_reg <= cfg_data;
        end
    end

    bcci_locate u_locate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .voltage   (s_axis_tdata[bcci_pkg::VoltW-1:0]),
        .lith      (lith_reg),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_beat  (loc_beat)
    );

    bcci_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_beat   (loc_beat),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_beat  (quot_beat)
    );

    always_comb
    begin
        logic [bcci_pkg::QuotW-1:0] shifted;
        shifted = quot_beat.quot >> quot_beat.shift;
        priority if (quot_beat.full)
        begin
            charge_next = bcci_pkg::FULL_CHARGE;
        end
        else if (quot_beat.empty)
        begin
            charge_next = '0;
        end
        else
        begin
            charge_next = shifted[bcci_pkg::ChargeW-1:0];
        end
    end

    assign quot_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (quot_ready)
        begin
            out_valid_reg <= quot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot_valid && quot_ready)
        begin
            charge_reg <= charge_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = charge_reg;

endmodule

### sim/battery_charge_curve_interpolator_top_tb.sv
// Self-checking testbench for the battery charge curve interpolator top level.
`timescale 1ns / 1ps

module battery_charge_curve_interpolator_top_tb;

    localparam int PIPE_DEPTH   = 4;
    localparam int RANDOM_ITEMS = 700;

    // curve knees, index 0 is the top of the curve
    localparam logic [7:0][12:0] LI_KNEE_MV =
        {13'd2500, 13'd2700, 13'd2750, 13'd2800, 13'd2850, 13'd2900, 13'd2950, 13'd3000};
    localparam logic [7:0][6:0] LI_KNEE_PCT =
        {7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd90, 7'd100};
    localparam logic [8:0][12:0] NIMH_KNEE_MV =
        {13'd2000, 13'd2100, 13'd2200, 13'd2300, 13'd2400, 13'd2500, 13'd2600, 13'd2700,
         13'd2900};
    localparam logic [8:0][6:0] NIMH_KNEE_PCT =
        {7'd0, 7'd3, 7'd12, 7'd30, 7'd50, 7'd65, 7'd80, 7'd90, 7'd100};

    typedef enum logic [1:0]
    {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_CHOKE
    } rx_mode_t;

    typedef struct packed
    {
        logic                         lith;
        logic [bcci_pkg::VoltW-1:0]   volts;
        logic                         typed;
        logic [bcci_pkg::ChargeW-1:0] want;
    } probe_row_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic               cfg_data      = 1'b1;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = 16'd0;   // [12:0] voltage_mv, [15:13] zero
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;            // [7:0] charge_half_percent

    logic [bcci_pkg::ChargeW-1:0] charge_expect_q [$];
    probe_row_t                   probe_table [$];
    logic [bcci_pkg::ChargeW-1:0] charge_want;
    logic               lith_sel      = 1'b1;
    int unsigned        mismatch_count = 0;
    int unsigned        rx_tick       = 0;
    rx_mode_t           rx_mode       = RX_OPEN;

    battery_charge_curve_interpolator_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned knee_mv(input logic lith, input int unsigned idx);
        return lith ? int'(LI_KNEE_MV[idx]) : int'(NIMH_KNEE_MV[idx]);
    endfunction

    function automatic int unsigned knee_pct(input logic lith, input int unsigned idx);
        return lith ? int'(LI_KNEE_PCT[idx]) : int'(NIMH_KNEE_PCT[idx]);
    endfunction

    // Linear interpolation between knees, doubled, rounded half up, exact integers.
    function automatic logic [bcci_pkg::ChargeW-1:0] predict_charge(
        input logic                       lith,
        input logic [bcci_pkg::VoltW-1:0] volts);
        int unsigned count;
        int unsigned v;
        int unsigned v1;
        int unsigned v2;
        int unsigned p1;
        int unsigned p2;
        int unsigned d;
        int unsigned num;
        logic [bcci_pkg::ChargeW-1:0] charge;
        logic done;
        count  = lith ? 8 : 9;
        v      = volts;
        charge = '0;
        done   = 1'b0;
        if (v >= knee_mv(lith, 0))
        begin
            charge = bcci_pkg::FULL_CHARGE;
        end
        else if (v > knee_mv(lith, count - 1))
        begin
            for (int unsigned i = 0; i + 1 < count; i++)
            begin
                v1 = knee_mv(lith, i);
                v2 = knee_mv(lith, i + 1);
                if (!done && v <= v1 && v >= v2)
                begin
                    p1     = knee_pct(lith, i);
                    p2     = knee_pct(lith, i + 1);
                    d      = v1 - v2;
                    num    = 2 * p1 * d - 2 * (v1 - v) * (p1 - p2);
                    charge = bcci_pkg::ChargeW'((2 * num + d) / (2 * d));
                    done   = 1'b1;
                end
            end
        end
        return charge;
    endfunction

    // Mostly the active span of the curve, some knees (+/-1), some anywhere.
    function automatic logic [bcci_pkg::VoltW-1:0] pick_voltage(input logic lith);
        int unsigned pick;
        int unsigned count;
        int unsigned knee;
        pick  = $urandom_range(0, 99);
        count = lith ? 8 : 9;
        if (pick < 12)
        begin
            knee = knee_mv(lith, $urandom_range(0, count - 1));
            return bcci_pkg::VoltW'(knee + $urandom_range(0, 2) - 1);
        end
        else if (pick < 32)
        begin
            return bcci_pkg::VoltW'($urandom_range(0, 8191));
        end
        return bcci_pkg::VoltW'($urandom_range(knee_mv(lith, count - 1) - 40,
                                               knee_mv(lith, 0) + 40));
    endfunction

    task automatic add_probe(input logic lith, input int unsigned volts, input logic typed,
                             input int unsigned want);
        probe_row_t row;
        row.lith  = lith;
        row.volts = bcci_pkg::VoltW'(volts);
        row.typed = typed;
        row.want  = bcci_pkg::ChargeW'(want);
        probe_table.push_back(row);
    endtask

    task automatic park_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (charge_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_chemistry(input logic lith);
        park_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= lith;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        lith_sel = lith;
    endtask

    task automatic send_voltage(input logic [bcci_pkg::VoltW-1:0]   volts,
                                input logic [bcci_pkg::ChargeW-1:0] want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, volts};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        charge_expect_q.push_back(want);
    endtask

    // result side: the stall pattern is redrawn at random from four modes
    always @(posedge clk)
    begin
        rx_tick = rx_tick + 1;
        if (rx_tick % 101 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        unique case (rx_mode)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB:  m_axis_tready <= (rx_tick % 8) < 5;
            default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (charge_expect_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none actual %0d",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                charge_want = charge_expect_q.pop_front();
                if (m_axis_tdata !== charge_want)
                begin
                    $display("%0t: charge_half_percent expected %0d actual %0d",
                             $time, charge_want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int unsigned burst_left;
        int unsigned gap;
        int unsigned phase_end;
        logic [bcci_pkg::VoltW-1:0] volts;

        // lithium: clamps, knees, the half-up rounding case near the bottom
        add_probe(1'b1,    0, 1'b1,   0);
        add_probe(1'b1, 8191, 1'b1, 200);
        add_probe(1'b1, 3000, 1'b1, 200);
        add_probe(1'b1, 2999, 1'b0,   0);
        add_probe(1'b1, 2975, 1'b0,   0);
        add_probe(1'b1, 2950, 1'b1, 180);
        add_probe(1'b1, 2900, 1'b1, 160);
        add_probe(1'b1, 2825, 1'b0,   0);
        add_probe(1'b1, 2700, 1'b1,  20);
        add_probe(1'b1, 2600, 1'b0,   0);
        add_probe(1'b1, 2505, 1'b0,   0);
        add_probe(1'b1, 2501, 1'b0,   0);
        add_probe(1'b1, 2500, 1'b1,   0);
        add_probe(1'b1, 4096, 1'b1, 200);
        // NiMH curve on doubled cell voltage
        add_probe(1'b0, 2900, 1'b1, 200);
        add_probe(1'b0, 2899, 1'b0,   0);
        add_probe(1'b0, 8191, 1'b1, 200);
        add_probe(1'b0, 2700, 1'b1, 180);
        add_probe(1'b0, 2500, 1'b1, 130);
        add_probe(1'b0, 2350, 1'b0,   0);
        add_probe(1'b0, 2100, 1'b1,   6);
        add_probe(1'b0, 2001, 1'b0,   0);
        add_probe(1'b0, 2000, 1'b1,   0);
        add_probe(1'b0,    0, 1'b1,   0);
        add_probe(1'b0, 3000, 1'b1, 200);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_table[i])
        begin
            if (probe_table[i].lith != lith_sel)
                write_chemistry(probe_table[i].lith);
            send_voltage(probe_table[i].volts,
                         probe_table[i].typed ? probe_table[i].want
                                              : predict_charge(lith_sel, probe_table[i].volts));
        end

        // random part: chemistry phases, sender in bursts with gaps
        burst_left = 0;
        phase_end  = 0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == phase_end)
            begin
                write_chemistry(1'($urandom_range(0, 1)));
                phase_end = phase_end + $urandom_range(60, 180);
            end
            volts = pick_voltage(lith_sel);
            send_voltage(volts, predict_charge(lith_sel, volts));
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 5);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
            begin
                burst_left--;
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (charge_expect_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH * 4) @(posedge clk);

        if (mismatch_count == 0 && charge_expect_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/bcci_pkg.sv
rtl/bcci_locate.sv
rtl/bcci_scale.sv
rtl/battery_charge_curve_interpolator_top.sv
sim/battery_charge_curve_interpolator_top_tb.sv
